// ===== sv/stable_counting_sort_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef STABLE_COUNTING_SORT_UNIT_DEFINES_SVH
`define STABLE_COUNTING_SORT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define SCSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scsu same-cycle check failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define SCSU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scsu next-cycle check failed");

`endif

// ===== sv/scsu_pkg.sv =====
package scsu_pkg;

  localparam int unsigned MAX_ITEMS_DEF   = 64;
  localparam int unsigned VALUE_COUNT_DEF = 256;
  localparam int unsigned VALUE_W         = 8;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_PFX_RD,
    ST_PFX_WR,
    ST_PL_RDV,
    ST_PL_RDC,
    ST_PL_WR,
    ST_EM_RD,
    ST_EM_OUT
  } state_e;

endpackage

// ===== sv/scsu_cnt_ram.sv =====
module scsu_cnt_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/stable_counting_sort_unit.sv =====
// non-final transaction: busy after the accepting edge through the count read-modify-write
// final transaction (n stored values, maximum m): count update, prefix pass over entries 0..m,
//   placement of the n values, then n results, each read from the result store and then shown,
//   then count-table clearing of entries 0..m; overflow transactions when full add no count update
// results cannot be stalled: each strobe lasts one cycle and is taken at its closing edge
// after reset the count table is swept to zero, all VALUE_COUNT entries, with busy high
module stable_counting_sort_unit
  import scsu_pkg::*;
#(
  parameter int unsigned MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int unsigned VALUE_COUNT = VALUE_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               last_i,
  output logic               result_valid_o,
  output logic [VALUE_W-1:0] sorted_value_o,
  output logic               last_res_o,
  output logic               overflow_o
);

  // index widths: count table, value/result stores, item counter
  localparam int unsigned IDX_W = $clog2(VALUE_COUNT);
  localparam int unsigned IW    = $clog2(MAX_ITEMS);
  localparam int unsigned NW    = $clog2(MAX_ITEMS + 1);

  state_e state_q, state_d;

  logic [IDX_W-1:0]   ptr_q;        // prefix / clear sweep pointer
  logic [IDX_W-1:0]   clr_lim_q;    // last entry of the clear sweep
  logic [NW-1:0]      sum_q;        // running prefix sum
  logic [VALUE_W-1:0] cur_val_q;    // value being counted
  logic               last_q;       // counted value closes the set
  logic [NW-1:0]      item_count_q;
  logic [VALUE_W-1:0] max_q;
  logic               dropped_q;
  logic [IW-1:0]      pl_idx_q;     // placement walks the input from the back
  logic [IW-1:0]      em_idx_q;     // emission index

  // stores of the set
  logic [VALUE_W-1:0] value_store  [MAX_ITEMS];
  logic [VALUE_W-1:0] result_store [MAX_ITEMS];
  logic [VALUE_W-1:0] vs_rd_q;
  logic [VALUE_W-1:0] rs_rd_q;

  // count table port
  logic             cnt_we;
  logic [IDX_W-1:0] cnt_waddr;
  logic [NW-1:0]    cnt_wdata;
  logic [IDX_W-1:0] cnt_raddr;
  logic [NW-1:0]    cnt_rdata;

  logic               accept;
  logic               full;
  logic [VALUE_W-1:0] sat_val;
  logic [IDX_W-1:0]   max_idx;
  logic [NW-1:0]      pfx_sum;
  logic [NW-1:0]      pos;
  logic [IW-1:0]      n_m1;

  assign accept  = start && !busy;
  assign full    = (item_count_q == NW'(MAX_ITEMS));
  assign max_idx = IDX_W'(max_q);
  assign pfx_sum = cnt_rdata + sum_q;
  // placement slot: count minus one, floored at zero
  assign pos     = (cnt_rdata == '0) ? '0 : cnt_rdata - NW'(1);
  assign n_m1    = IW'(item_count_q - NW'(1));

  // values beyond the table saturate to its top entry
  always_comb begin
    if (32'(value_i) >= 32'(VALUE_COUNT)) begin
      sat_val = VALUE_W'(VALUE_COUNT - 1);
    end else begin
      sat_val = value_i;
    end
  end

  scsu_cnt_ram #(
    .DEPTH  (VALUE_COUNT),
    .ADDR_W (IDX_W),
    .DATA_W (NW)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (ptr_q == clr_lim_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (!full) state_d = ST_CNT_RD;
          else if (last_i) state_d = ST_PFX_RD;
        end
      end
      ST_CNT_RD: state_d = ST_CNT_WR;
      ST_CNT_WR: state_d = last_q ? ST_PFX_RD : ST_IDLE;
      ST_PFX_RD: state_d = ST_PFX_WR;
      ST_PFX_WR: state_d = (ptr_q == max_idx) ? ST_PL_RDV : ST_PFX_RD;
      ST_PL_RDV: state_d = ST_PL_RDC;
      ST_PL_RDC: state_d = ST_PL_WR;
      ST_PL_WR:  state_d = (pl_idx_q == '0) ? ST_EM_RD : ST_PL_RDV;
      ST_EM_RD:  state_d = ST_EM_OUT;
      ST_EM_OUT: state_d = (em_idx_q == n_m1) ? ST_CLEAR : ST_EM_RD;
      default:   state_d = ST_IDLE;
    endcase
  end

  // count table control and handshake outputs
  always_comb begin
    cnt_we         = 1'b0;
    cnt_waddr      = ptr_q;
    cnt_wdata      = '0;
    cnt_raddr      = ptr_q;
    busy           = (state_q != ST_IDLE);
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_we = 1'b1;
      end
      ST_CNT_RD: begin
        cnt_raddr = IDX_W'(cur_val_q);
      end
      ST_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = IDX_W'(cur_val_q);
        cnt_wdata = cnt_rdata + NW'(1);
      end
      ST_PFX_WR: begin
        cnt_we    = 1'b1;
        cnt_wdata = pfx_sum;
      end
      ST_PL_RDC: begin
        cnt_raddr = IDX_W'(vs_rd_q);
      end
      ST_PL_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = IDX_W'(vs_rd_q);
        cnt_wdata = pos;
      end
      ST_EM_OUT: begin
        result_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sorted_value_o = rs_rd_q;
  assign last_res_o     = (em_idx_q == n_m1);
  assign overflow_o     = dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q        <= '0;
      clr_lim_q    <= IDX_W'(VALUE_COUNT - 1);
      sum_q        <= '0;
      cur_val_q    <= '0;
      last_q       <= 1'b0;
      item_count_q <= '0;
      max_q        <= '0;
      dropped_q    <= 1'b0;
      pl_idx_q     <= '0;
      em_idx_q     <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          ptr_q <= (ptr_q == clr_lim_q) ? '0 : ptr_q + IDX_W'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            if (!full) begin
              cur_val_q    <= sat_val;
              last_q       <= last_i;
              item_count_q <= item_count_q + NW'(1);
              if (sat_val > max_q) max_q <= sat_val;
            end else begin
              dropped_q <= 1'b1;
              ptr_q     <= '0;
              sum_q     <= '0;
            end
          end
        end
        ST_CNT_WR: begin
          ptr_q <= '0;
          sum_q <= '0;
        end
        ST_PFX_WR: begin
          sum_q <= pfx_sum;
          if (ptr_q == max_idx) begin
            ptr_q    <= '0;
            pl_idx_q <= n_m1;
          end else begin
            ptr_q <= ptr_q + IDX_W'(1);
          end
        end
        ST_PL_WR: begin
          if (pl_idx_q == '0) begin
            em_idx_q <= '0;
          end else begin
            pl_idx_q <= pl_idx_q - IW'(1);
          end
        end
        ST_EM_OUT: begin
          if (em_idx_q == n_m1) begin
            // set done: sweep the touched part of the count table
            clr_lim_q    <= max_idx;
            ptr_q        <= '0;
            item_count_q <= '0;
            max_q        <= '0;
            dropped_q    <= 1'b0;
          end else begin
            em_idx_q <= em_idx_q + IW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // value and result stores, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (accept && !full) begin
      value_store[item_count_q[IW-1:0]] <= sat_val;
    end
    vs_rd_q <= value_store[pl_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PL_WR) begin
      result_store[pos[IW-1:0]] <= vs_rd_q;
    end
    rs_rd_q <= result_store[em_idx_q];
  end

endmodule

// ===== sv/scsu_checker.sv =====
`include "stable_counting_sort_unit_defines.svh"

module scsu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_i,
  input logic result_valid_o,
  input logic last_res_o,
  input logic overflow_o
);

  // results only come out while a set is being worked on
  `SCSU_ASSERT_IMP(a_result_while_busy, result_valid_o, busy)
  // results never come back to back
  `SCSU_ASSERT_NXT(a_result_spacing, result_valid_o, !result_valid_o)
  // overflow flag is the same on every result of a set
  `SCSU_ASSERT_IMP(a_overflow_steady, result_valid_o && !last_res_o,
                   ##2 (result_valid_o && (overflow_o == $past(overflow_o, 2))))
  // the final result is followed by the table clearing sweep
  `SCSU_ASSERT_NXT(a_clear_after_last, result_valid_o && last_res_o, busy)
  // a transaction that closes a set starts the sort
  `SCSU_ASSERT_NXT(a_last_starts_sort, start && !busy && last_i, busy)

endmodule

bind stable_counting_sort_unit scsu_checker u_scsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .last_i         (last_i),
  .result_valid_o (result_valid_o),
  .last_res_o     (last_res_o),
  .overflow_o     (overflow_o)
);
